[hw/rtl/pfvs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pfvs_pkg
// Shared constants and types of the plug-flow volume shunt.
// ----------------------------------------------------------------------------
package pfvs_pkg;
    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int VOL_W  = 24;
    localparam int CONC_W = 16;
    localparam int PEND_W = 32;
    localparam int NUM_W  = CONC_W + VOL_W + 1;   // signed numerator
    localparam int DIV_W  = VOL_W + CONC_W;       // magnitude dividend

    typedef struct packed {
        logic [VOL_W-1:0]  vol;
        logic [CONC_W-1:0] top;
        logic [CONC_W-1:0] bot;
    } t_elem;
endpackage
`default_nettype wire

[hw/rtl/pfvs_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pfvs_div
// Restoring divider, one quotient bit per cycle, rounding half away from zero.
// ----------------------------------------------------------------------------
module pfvs_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [pfvs_pkg::DIV_W-1:0]    i_num,
    input  wire logic [pfvs_pkg::VOL_W-1:0]    i_den,
    output logic                               o_done,
    output logic      [pfvs_pkg::DIV_W-1:0]    o_quot
);
    localparam int STEP_W = $clog2(pfvs_pkg::DIV_W + 1);

    logic [pfvs_pkg::DIV_W-1:0] r_num;
    logic [pfvs_pkg::VOL_W-1:0] r_rem;
    logic [pfvs_pkg::VOL_W-1:0] r_den;
    logic [STEP_W-1:0]          r_step;
    logic                       r_busy;
    logic [pfvs_pkg::VOL_W:0]   w_trial;
    logic [pfvs_pkg::VOL_W+1:0] w_diff;

    // Dividend is pre-biased by den/2 so truncation gives rounded magnitude.
    assign w_trial = {r_rem, r_num[pfvs_pkg::DIV_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(pfvs_pkg::DIV_W);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                // The remainder always stays below the divisor.
                if (!w_diff[pfvs_pkg::VOL_W+1]) begin
                    r_rem <= w_diff[pfvs_pkg::VOL_W-1:0];
                end else begin
                    r_rem <= w_trial[pfvs_pkg::VOL_W-1:0];
                end
                r_num <= {r_num[pfvs_pkg::DIV_W-2:0], ~w_diff[pfvs_pkg::VOL_W+1]};
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quot = r_num;
endmodule
`default_nettype wire

[hw/rtl/plug_flow_volume_shunt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// plug_flow_volume_shunt
// Plug-flow deque of gas volume elements with batch push-out and splitting.
// ----------------------------------------------------------------------------
// Sequence: an insert without batch end passes S_INS and S_CHECK, plus S_WAIT if dropped. A batch end adds a
// pass through S_CHECK, each whole element pushed out passes S_READ, S_DECIDE, S_OUT and S_WAIT,
// and a split adds S_MUL, S_DIVW (waiting on the one-bit-per-cycle divider) and S_FIX; output stalls lengthen S_WAIT.
// Throughput: one item at a time; the next is accepted after the last result.
// Reset: synchronous, active low; the store holds one zero-volume element.
module plug_flow_volume_shunt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: elem_volume[23:0], conc_top[39:24], conc_bottom[55:40]
    input  wire logic [55:0] s_axis_tdata,
    // tuser: cmd
    input  wire logic        s_axis_tuser,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: out_volume[23:0], out_conc_top[39:24], out_conc_bottom[55:40]
    output logic      [55:0] m_axis_tdata,
    // tuser: dropped
    output logic             m_axis_tuser,
    output logic             m_axis_tlast
);
    typedef enum logic [3:0] {
        S_IDLE, S_INS, S_CHECK, S_READ, S_DECIDE, S_MUL, S_DIVW, S_FIX,
        S_OUT, S_WAIT
    } t_state;

    t_state r_state;
    pfvs_pkg::t_elem r_mem [pfvs_pkg::DEPTH];
    pfvs_pkg::t_elem r_in, r_rd, r_res;
    logic [pfvs_pkg::IDX_W-1:0]  r_head, r_addr;
    logic [pfvs_pkg::CNT_W-1:0]  r_count;
    logic [pfvs_pkg::PEND_W-1:0] r_pend, r_left;
    logic [pfvs_pkg::CNT_W-1:0]  r_nout;
    logic r_up, r_end, r_drop, r_split, r_any, r_neg;
    logic [pfvs_pkg::NUM_W-1:0]  r_prod;
    logic [pfvs_pkg::DIV_W-1:0]  w_mag;
    logic                        w_dstart, w_ddone;
    logic [pfvs_pkg::DIV_W-1:0]  w_quot;
    logic [pfvs_pkg::PEND_W:0]   w_sum;
    logic [pfvs_pkg::IDX_W-1:0]  w_tail;
    logic signed [pfvs_pkg::CONC_W+1:0] w_dc, w_newc;
    logic [pfvs_pkg::VOL_W-1:0]  w_rem_vol;
    logic w_more;

    assign w_sum  = {1'b0, r_pend} + (pfvs_pkg::PEND_W+1)'(r_in.vol);
    assign w_tail = r_head + pfvs_pkg::IDX_W'(r_count - 1'b1);
    // Remaining volume fits in 24 bits whenever a split happens.
    assign w_rem_vol = r_rd.vol - r_left[pfvs_pkg::VOL_W-1:0];
    // Up mode interpolates from bottom toward top, down mode the reverse.
    assign w_dc = r_up ? ($signed({2'b00, r_rd.top}) - $signed({2'b00, r_rd.bot}))
                       : ($signed({2'b00, r_rd.bot}) - $signed({2'b00, r_rd.top}));
    assign w_mag = r_prod[pfvs_pkg::NUM_W-1]
        ? pfvs_pkg::DIV_W'(-r_prod) + pfvs_pkg::DIV_W'(r_rd.vol >> 1)
        : pfvs_pkg::DIV_W'(r_prod) + pfvs_pkg::DIV_W'(r_rd.vol >> 1);
    assign w_newc = (r_up ? $signed({2'b00, r_rd.bot}) : $signed({2'b00, r_rd.top}))
        + (r_neg ? -$signed({1'b0, w_quot[pfvs_pkg::CONC_W:0]})
                 :  $signed({1'b0, w_quot[pfvs_pkg::CONC_W:0]}));
    assign w_dstart = (r_state == S_MUL);
    assign w_more = !r_split && (r_left != '0) && (r_count != '0)
                    && (r_nout != pfvs_pkg::CNT_W'(pfvs_pkg::DEPTH));

    pfvs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_mag),
        .i_den   (r_rd.vol),
        .o_done  (w_ddone),
        .o_quot  (w_quot)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_WAIT);
    assign m_axis_tdata  = {r_res.bot, r_res.top, r_res.vol};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // The one live element after reset sits at the head slot.
            r_mem[pfvs_pkg::IDX_W'(0)] <= '0;
        end else begin
            if (r_state == S_INS && !r_drop) begin
                r_mem[r_addr] <= r_in;
            end
            if (r_state == S_FIX) begin
                r_mem[r_addr] <= r_up
                    ? pfvs_pkg::t_elem'{w_rem_vol, w_newc[pfvs_pkg::CONC_W-1:0], r_rd.bot}
                    : pfvs_pkg::t_elem'{w_rem_vol, r_rd.top, w_newc[pfvs_pkg::CONC_W-1:0]};
            end
        end
        if (r_state == S_READ) begin
            r_rd <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= pfvs_pkg::CNT_W'(1);
            r_pend  <= '0;
            m_axis_tlast <= 1'b0;
            m_axis_tuser <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_in  <= pfvs_pkg::t_elem'{s_axis_tdata[23:0],
                                 s_axis_tdata[39:24], s_axis_tdata[55:40]};
                        r_up  <= s_axis_tuser;
                        r_end <= s_axis_tlast;
                        r_nout <= '0;
                        r_any  <= 1'b0;
                        r_split <= 1'b0;
                        // Volume left over from an earlier removal is discarded.
                        r_left <= '0;
                        r_drop <= (r_count == pfvs_pkg::CNT_W'(pfvs_pkg::DEPTH));
                        if (s_axis_tuser) begin
                            r_addr <= r_head + pfvs_pkg::IDX_W'(r_count);
                        end else begin
                            r_addr <= r_head - 1'b1;
                        end
                        r_state <= S_INS;
                    end
                end
                S_INS: begin
                    if (!r_drop) begin
                        if (!r_up) begin
                            r_head <= r_addr;
                        end
                        r_count <= r_count + 1'b1;
                        r_pend <= w_sum[pfvs_pkg::PEND_W] ? '1 : w_sum[pfvs_pkg::PEND_W-1:0];
                    end
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_end) begin
                        r_left <= r_pend;
                        r_pend <= '0;
                        r_end  <= 1'b0;
                        r_state <= S_CHECK;
                    end else if (w_more) begin
                        r_addr  <= r_up ? r_head : w_tail;
                        r_state <= S_READ;
                    end else if (r_drop && !r_any) begin
                        r_res <= '0;
                        m_axis_tlast <= 1'b0;
                        m_axis_tuser <= 1'b1;
                        r_any <= 1'b1;
                        r_state <= S_WAIT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_READ: r_state <= S_DECIDE;
                S_DECIDE: begin
                    if (r_up ? ({8'd0, r_rd.vol} > r_left) : ({8'd0, r_rd.vol} >= r_left)) begin
                        r_split <= 1'b1;
                        r_prod <= pfvs_pkg::NUM_W'(w_dc * $signed({1'b0, w_rem_vol}));
                        r_neg  <= w_dc[pfvs_pkg::CONC_W+1];
                        r_state <= S_MUL;
                    end else begin
                        r_res <= r_rd;
                        r_left <= r_left - pfvs_pkg::PEND_W'(r_rd.vol);
                        if (r_up) begin
                            r_head <= r_head + 1'b1;
                        end
                        r_count <= r_count - 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_MUL: r_state <= S_DIVW;
                S_DIVW: begin
                    if (w_ddone) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    r_res <= r_up
                        ? pfvs_pkg::t_elem'{r_left[pfvs_pkg::VOL_W-1:0], r_rd.top,
                                            w_newc[pfvs_pkg::CONC_W-1:0]}
                        : pfvs_pkg::t_elem'{r_left[pfvs_pkg::VOL_W-1:0],
                                            w_newc[pfvs_pkg::CONC_W-1:0], r_rd.bot};
                    r_left <= '0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_nout <= r_nout + 1'b1;
                    r_any  <= 1'b1;
                    m_axis_tuser <= r_drop;
                    m_axis_tlast <= !w_more || (r_nout == pfvs_pkg::CNT_W'(pfvs_pkg::DEPTH - 1));
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (m_axis_tready) begin
                        r_state <= S_CHECK;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pfvs_pkg::CNT_W'(pfvs_pkg::DEPTH))
        else $error("element count above depth");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready)
        else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
endmodule
`default_nettype wire

[tb/plug_flow_volume_shunt_tb.sv]
// ----------------------------------------------------------------------------
// plug_flow_volume_shunt_tb
// Drives batches of volume elements into the shunt in both modes, predicts
// every pushed-out piece with a model of the deque kept in the testbench and
// checks each output transaction field by field, under random source gaps
// and sink stalls.
// ----------------------------------------------------------------------------
module plug_flow_volume_shunt_tb;
    localparam int DEPTH  = pfvs_pkg::DEPTH;
    localparam int VOL_W  = pfvs_pkg::VOL_W;
    localparam int CONC_W = pfvs_pkg::CONC_W;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_CYCLES = 400;

    typedef pfvs_pkg::t_elem t_elem;

    typedef struct {
        logic [VOL_W-1:0]  vol;
        logic [CONC_W-1:0] top;
        logic [CONC_W-1:0] bot;
        logic              last;
        logic              drop;
    } t_piece;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    // Deque mirror used for prediction.
    t_elem       deque_mem [DEPTH];
    int          deque_head;
    int          deque_count;
    logic [31:0] pending_sum;

    t_piece      piece_q[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          sink_phase = 0;
    logic        sink_free = 1'b1;

    plug_flow_volume_shunt dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Sink alternates between free-running stretches and random stalling.
    always @(posedge i_clk) begin
        if (sink_phase == 0) begin
            sink_phase <= $urandom_range(20, 200);
            sink_free  <= ($urandom_range(0, 2) == 0);
        end else begin
            sink_phase <= sink_phase - 1;
        end
        m_axis_tready <= sink_free ? 1'b1 : ($urandom_range(0, 2) != 0);
    end

    function automatic logic [CONC_W-1:0] lerp_conc(logic [CONC_W-1:0] a, logic [CONC_W-1:0] b,
                                                     logic [VOL_W-1:0] v, logic [31:0] l);
        longint num;
        longint q;
        longint vv;
        vv  = longint'(v);
        num = (longint'(b) - longint'(a)) * (vv - longint'(l));
        if (num >= 0)
            q = (num + vv / 2) / vv;
        else
            q = -((-num + vv / 2) / vv);
        return CONC_W'(longint'(a) + q);
    endfunction

    function automatic void predict_shunt(logic up, logic [VOL_W-1:0] v, logic [CONC_W-1:0] ct,
                                          logic [CONC_W-1:0] cb, logic batch_end);
        logic        drop;
        logic [31:0] left;
        int          s;
        logic        split;
        logic [CONC_W-1:0] nc;
        t_piece      pcs[$];
        t_piece      p;
        drop = 1'b0;
        if (deque_count >= DEPTH) begin
            drop = 1'b1;
        end else begin
            if (up) begin
                s = (deque_head + deque_count) % DEPTH;
            end else begin
                deque_head = (deque_head + DEPTH - 1) % DEPTH;
                s = deque_head;
            end
            deque_mem[s] = '{vol: v, top: ct, bot: cb};
            deque_count++;
            if (pending_sum > 32'hFFFF_FFFF - 32'(v))
                pending_sum = 32'hFFFF_FFFF;
            else
                pending_sum = pending_sum + 32'(v);
        end
        if (batch_end) begin
            left = pending_sum;
            pending_sum = '0;
            while (left > 0 && deque_count > 0 && pcs.size() < DEPTH) begin
                s = up ? deque_head : (deque_head + deque_count - 1) % DEPTH;
                split = up ? (32'(deque_mem[s].vol) > left) : (32'(deque_mem[s].vol) >= left);
                p.last = 1'b0;
                p.drop = 1'b0;
                if (split) begin
                    p.vol = VOL_W'(left);
                    if (up) begin
                        nc = lerp_conc(deque_mem[s].bot, deque_mem[s].top, deque_mem[s].vol, left);
                        p.top = deque_mem[s].top;
                        p.bot = nc;
                        deque_mem[s].top = nc;
                    end else begin
                        nc = lerp_conc(deque_mem[s].top, deque_mem[s].bot, deque_mem[s].vol, left);
                        p.top = nc;
                        p.bot = deque_mem[s].bot;
                        deque_mem[s].bot = nc;
                    end
                    deque_mem[s].vol = deque_mem[s].vol - VOL_W'(left);
                    left = '0;
                end else begin
                    p.vol = deque_mem[s].vol;
                    p.top = deque_mem[s].top;
                    p.bot = deque_mem[s].bot;
                    left = left - 32'(deque_mem[s].vol);
                    if (up)
                        deque_head = (deque_head + 1) % DEPTH;
                    deque_count--;
                end
                pcs = {pcs, p};
            end
            if (pcs.size() > 0)
                pcs[pcs.size()-1].last = 1'b1;
        end
        if (drop && pcs.size() == 0) begin
            p = '{vol: '0, top: '0, bot: '0, last: 1'b0, drop: 1'b0};
            pcs = {pcs, p};
        end
        foreach (pcs[k]) begin
            pcs[k].drop = drop;
            piece_q = {piece_q, pcs[k]};
        end
    endfunction

    // One input transaction, followed by a random gap at the end of a burst.
    task automatic send_item(logic up, logic [VOL_W-1:0] v, logic [CONC_W-1:0] ct,
                             logic [CONC_W-1:0] cb, logic batch_end);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cb, ct, v};
        s_axis_tuser  <= up;
        s_axis_tlast  <= batch_end;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_shunt(up, v, ct, cb, batch_end);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_piece e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (piece_q.size() == 0) begin
                $display("%0t: unexpected output transaction, actual data %h user %b last %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                error_count++;
            end else begin
                e = piece_q.pop_front();
                if (m_axis_tdata[23:0] !== e.vol) begin
                    $display("%0t: out_volume expected %h actual %h", $time, e.vol,
                             m_axis_tdata[23:0]);
                    error_count++;
                end
                if (m_axis_tdata[39:24] !== e.top) begin
                    $display("%0t: out_conc_top expected %h actual %h", $time, e.top,
                             m_axis_tdata[39:24]);
                    error_count++;
                end
                if (m_axis_tdata[55:40] !== e.bot) begin
                    $display("%0t: out_conc_bottom expected %h actual %h", $time, e.bot,
                             m_axis_tdata[55:40]);
                    error_count++;
                end
                if (m_axis_tlast !== e.last) begin
                    $display("%0t: last_piece expected %b actual %b", $time, e.last,
                             m_axis_tlast);
                    error_count++;
                end
                if (m_axis_tuser !== e.drop) begin
                    $display("%0t: dropped expected %b actual %b", $time, e.drop,
                             m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    task automatic test_down_mode;
        // Exact fit: the element equals the remainder, so down mode splits it.
        send_item(1'b0, 24'h000200, 16'h0000, 16'hFFFF, 1'b1);
        send_item(1'b0, 24'hFFFFFF, 16'hFFFF, 16'h0000, 1'b0);
        send_item(1'b0, 24'h000000, 16'h1234, 16'h8765, 1'b0);
        send_item(1'b0, 24'h000155, 16'hFFFF, 16'hFFFF, 1'b1);
        send_item(1'b0, 24'h000001, 16'h0000, 16'hFFFF, 1'b1);
    endtask

    task automatic test_up_mode;
        send_item(1'b1, 24'h000300, 16'hFFFF, 16'h0000, 1'b0);
        send_item(1'b1, 24'h000100, 16'h4000, 16'hC000, 1'b1);
        send_item(1'b1, 24'h800000, 16'h0001, 16'hFFFE, 1'b1);
        send_item(1'b1, 24'h000007, 16'hAAAA, 16'h5555, 1'b1);
    endtask

    task automatic test_empty_batch_end;
        send_item(1'b0, 24'h000000, 16'h0F0F, 16'hF0F0, 1'b1);
        send_item(1'b1, 24'h000000, 16'h0000, 16'h0000, 1'b1);
    endtask

    task automatic test_mixed_modes;
        send_item(1'b1, 24'h000040, 16'h1111, 16'h2222, 1'b0);
        send_item(1'b0, 24'h000080, 16'h3333, 16'h4444, 1'b0);
        send_item(1'b1, 24'h000123, 16'h5555, 16'h6666, 1'b1);
        send_item(1'b0, 24'h000050, 16'h7777, 16'h8888, 1'b0);
        send_item(1'b1, 24'h000060, 16'h9999, 16'hAAAA, 1'b0);
        send_item(1'b0, 24'h000010, 16'hBBBB, 16'hCCCC, 1'b1);
    endtask

    // Fill the store past its depth, then push out a long down-mode batch and a short up-mode one.
    task automatic test_full_store;
        for (int k = 0; k < DEPTH + 4; k++)
            send_item(1'($urandom_range(0, 1)), VOL_W'($urandom_range(1, 255)),
                      CONC_W'($urandom), CONC_W'($urandom), 1'b0);
        send_item(1'b0, 24'h000020, 16'h0000, 16'h0000, 1'b1);
        send_item(1'b1, 24'h000020, 16'hFFFF, 16'h0000, 1'b1);
    endtask

    task automatic test_random;
        int blen;
        int sent;
        logic [VOL_W-1:0] v;
        sent = 0;
        while (sent < 60) begin
            blen = $urandom_range(1, 8);
            for (int k = 0; k < blen; k++) begin
                case ($urandom_range(0, 7))
                    0:       v = VOL_W'($urandom);
                    1:       v = '0;
                    default: v = VOL_W'($urandom_range(1, 16'h0FFF));
                endcase
                send_item(1'($urandom_range(0, 1)), v, CONC_W'($urandom), CONC_W'($urandom),
                          (k == blen - 1) || ($urandom_range(0, 15) == 0));
                sent++;
            end
        end
    endtask

    initial begin
        foreach (deque_mem[k])
            deque_mem[k] = '0;
        deque_head  = 0;
        deque_count = 1;
        pending_sum = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_down_mode();
        test_up_mode();
        test_empty_batch_end();
        test_mixed_modes();
        test_full_store();
        test_random();
        s_axis_tvalid <= 1'b0;
        while (piece_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
